FILE: rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fixed-point ALU
// Word format, operation codes, status codes and the side-result struct.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 8;
	localparam int DVD_W     = WORD_W + FRAC_BITS;   // dividend and quotient width
	localparam int REM_W     = WORD_W;
	localparam int PROD_W    = 2 * WORD_W;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_INC      = 4'd4,
		OP_DEC      = 4'd5,
		OP_LT       = 4'd6,
		OP_GT       = 4'd7,
		OP_LE       = 4'd8,
		OP_GE       = 4'd9,
		OP_EQ       = 4'd10,
		OP_NE       = 4'd11,
		OP_MIN      = 4'd12,
		OP_MAX      = 4'd13,
		OP_TO_INT   = 4'd14,
		OP_FROM_INT = 4'd15
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	// result of every operation but divide, riding alongside the divider
	typedef struct packed {
		op_t                 op;
		logic [WORD_W-1:0]   value;
		logic                cmp;
		logic [1:0]          status;
	} side_t;

endpackage
`default_nettype wire

FILE: rtl/core/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div: pipelined signed fixed-point divider
// (a << FRAC_BITS) / b truncated toward zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_vld,
	input  wire logic [fpa_pkg::WORD_W-1:0]  a,
	input  wire logic [fpa_pkg::WORD_W-1:0]  b,
	input  wire fpa_pkg::side_t              side_in,
	output logic                             out_vld,
	output logic [fpa_pkg::WORD_W-1:0]       quot,
	output logic [1:0]                       quot_status,
	output fpa_pkg::side_t                   side_out
);
	import fpa_pkg::*;

	localparam int STEPS = DVD_W;

	logic               v_s   [STEPS+1];
	logic [DVD_W-1:0]   n_s   [STEPS+1];
	logic [REM_W-1:0]   r_s   [STEPS+1];
	logic [WORD_W-1:0]  d_s   [STEPS+1];
	logic               neg_s [STEPS+1];
	logic               dz_s  [STEPS+1];
	side_t              tag_s [STEPS+1];

	logic [WORD_W-1:0]  a_mag, b_mag;

	// magnitudes: the most negative word maps to 2^(W-1), still fits unsigned
	assign a_mag = a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
	assign b_mag = b[WORD_W-1] ? (~b + WORD_W'(1)) : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]   <= {a_mag, {FRAC_BITS{1'b0}}};
			r_s[0]   <= '0;
			d_s[0]   <= b_mag;
			neg_s[0] <= a[WORD_W-1] ^ b[WORD_W-1];
			dz_s[0]  <= (b == '0);
			tag_s[0] <= side_in;
		end
	end

	// restoring steps; quotient bits shift into n from the bottom
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [REM_W:0]   t;
		logic [REM_W+1:0] diff;
		logic             ge;

		assign t    = {r_s[i], n_s[i][DVD_W-1]};
		assign diff = {1'b0, t} - {2'b00, d_s[i]};
		assign ge   = ~diff[REM_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1]   <= {n_s[i][DVD_W-2:0], ge};
				r_s[i+1]   <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
				d_s[i+1]   <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				dz_s[i+1]  <= dz_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	// sign fix and range check
	logic [DVD_W-1:0] qm, qs;
	logic             ovf;

	assign qm  = n_s[STEPS];
	assign qs  = neg_s[STEPS] ? (~qm + DVD_W'(1)) : qm;
	assign ovf = neg_s[STEPS] ? (qm > (DVD_W'(1) << (WORD_W-1)))
	                          : (qm > ((DVD_W'(1) << (WORD_W-1)) - DVD_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= tag_s[STEPS];
			if (dz_s[STEPS]) begin
				quot        <= '0;
				quot_status <= ST_DIV0;
			end else begin
				quot        <= qs[WORD_W-1:0];
				quot_status <= ovf ? ST_OVF : ST_OK;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/fixed_point_alu.sv
// An accepted request word passes stages 1 to 3, the divider and the output register.
// Throughput: one word per cycle; the whole pipeline advances together
// and holds while the output word waits for out_ready.
// The depth is set by the divider, one quotient bit per stage (40 stages).
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// fixed_point_alu: signed Q24.8 fixed-point ALU
// Add, sub, mul, div, inc/dec, compares, min/max and integer conversions.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_alu (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [3:0]                  req_type,
	input  wire logic signed [fpa_pkg::WORD_W-1:0] operand_a,
	input  wire logic signed [fpa_pkg::WORD_W-1:0] operand_b,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [fpa_pkg::WORD_W-1:0] result_value,
	output logic                             compare_true,
	output logic [1:0]                       status
);
	import fpa_pkg::*;

	// one enable for every stage: move unless the output word is stuck
	logic en;
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;

	// ---- stage 1: capture request ----
	logic                      v_s1;
	op_t                       op_s1;
	logic signed [WORD_W-1:0]  a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_t'(req_type);
			a_s1  <= operand_a;
			b_s1  <= operand_b;
		end
	end

	// ---- stage 2: product, sums, compares, conversions ----
	logic signed [WORD_W:0]   sum_x;
	logic signed [WORD_W:0]   a_x, b_x;
	logic signed [DVD_W-1:0]  fi;
	logic signed [WORD_W:0]   ti;
	logic                     lt, eq;
	logic [WORD_W-1:0]        val_c;
	logic                     cmp_c;
	logic [1:0]               st_c;

	assign a_x = {a_s1[WORD_W-1], a_s1};
	assign b_x = {b_s1[WORD_W-1], b_s1};
	assign lt  = a_s1 < b_s1;
	assign eq  = a_s1 == b_s1;
	assign fi  = {a_s1, {FRAC_BITS{1'b0}}};
	// truncate toward zero: bias negatives before the arithmetic shift
	assign ti  = a_x + (a_s1[WORD_W-1] ? (WORD_W+1)'((1 << FRAC_BITS) - 1) : '0);

	always_comb begin
		sum_x = '0;
		val_c = '0;
		cmp_c = 1'b0;
		st_c  = ST_OK;
		unique case (op_s1)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				unique case (op_s1)
					OP_ADD:  sum_x = a_x + b_x;
					OP_SUB:  sum_x = a_x - b_x;
					OP_INC:  sum_x = a_x + (WORD_W+1)'(1);
					default: sum_x = a_x - (WORD_W+1)'(1);
				endcase
				val_c = sum_x[WORD_W-1:0];
				st_c  = (sum_x[WORD_W] != sum_x[WORD_W-1]) ? ST_OVF : ST_OK;
			end
			OP_LT:  cmp_c = lt;
			OP_GT:  cmp_c = ~lt & ~eq;
			OP_LE:  cmp_c = lt | eq;
			OP_GE:  cmp_c = ~lt;
			OP_EQ:  cmp_c = eq;
			OP_NE:  cmp_c = ~eq;
			OP_MIN: val_c = lt ? a_s1 : b_s1;
			OP_MAX: val_c = (~lt & ~eq) ? a_s1 : b_s1;
			OP_TO_INT: val_c = {{(FRAC_BITS-1){ti[WORD_W]}}, ti[WORD_W:FRAC_BITS]};
			OP_FROM_INT: begin
				val_c = fi[WORD_W-1:0];
				st_c  = (fi[DVD_W-1:WORD_W-1] != {(FRAC_BITS+1){fi[WORD_W-1]}})
				        ? ST_OVF : ST_OK;
			end
			default: ;   // mul and div finish later
		endcase
	end

	logic                      v_s2;
	op_t                       op_s2;
	logic signed [WORD_W-1:0]  a_s2, b_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	side_t                     side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			prod_s2 <= a_s1 * b_s1;
			side_s2 <= '{op: op_s1, value: val_c, cmp: cmp_c, status: st_c};
		end
	end

	// ---- stage 3: scale product back, truncating toward zero ----
	logic signed [PROD_W-1:0] pb, pq;
	logic                     p_ovf;
	side_t                    side_m;

	assign pb    = prod_s2 + (prod_s2[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
	assign pq    = pb >>> FRAC_BITS;
	assign p_ovf = pq[PROD_W-1:WORD_W-1] != {(PROD_W-WORD_W+1){pq[WORD_W-1]}};

	always_comb begin
		side_m = side_s2;
		if (op_s2 == OP_MUL) begin
			side_m.value  = pq[WORD_W-1:0];
			side_m.status = p_ovf ? ST_OVF : ST_OK;
		end
	end

	logic                     v_s3;
	logic [WORD_W-1:0]        a_s3, b_s3;
	side_t                    side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			side_s3 <= side_m;
		end
	end

	// ---- divider: carries the other results alongside ----
	logic              dv_vld;
	logic [WORD_W-1:0] dv_quot;
	logic [1:0]        dv_status;
	side_t             dv_side;

	fpa_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (v_s3),
		.a           (a_s3),
		.b           (b_s3),
		.side_in     (side_s3),
		.out_vld     (dv_vld),
		.quot        (dv_quot),
		.quot_status (dv_status),
		.side_out    (dv_side)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_side.op == OP_DIV) begin
				result_value <= dv_quot;
				compare_true <= 1'b0;
				status       <= dv_status;
			end else begin
				result_value <= dv_side.value;
				compare_true <= dv_side.cmp;
				status       <= dv_side.status;
			end
		end
	end

endmodule
`default_nettype wire

FILE: bench/alu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alu_checker: result predictor and scoreboard for the fixed-point ALU
// Computes the expected result word of each accepted request word and
// compares it, field by field, with the words leaving the block.
// ----------------------------------------------------------------------------
module alu_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [3:0]                        req_type,
	input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
	input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [fpa_pkg::WORD_W-1:0] result_value,
	input  logic                              compare_true,
	input  logic [1:0]                        status,
	output int                                fail_count,
	output int                                pending
);
	import fpa_pkg::*;

	typedef struct {
		logic [WORD_W-1:0] value;
		logic              cmp;
		logic [1:0]        st;
	} alu_word_t;

	alu_word_t expected_words[$];

	function automatic alu_word_t alu_predict(logic [3:0] code, logic signed [31:0] a,
		logic signed [31:0] b);
		alu_word_t r;
		longint x, y, exact, scale;
		logic arith;
		op_t op;
		op = op_t'(code);
		x = a;
		y = b;
		scale = longint'(1) << FRAC_BITS;
		exact = 0;
		arith = 1'b1;
		r.cmp = 1'b0;
		r.st = ST_OK;
		case (op)
			OP_ADD:      exact = x + y;
			OP_SUB:      exact = x - y;
			OP_MUL:      exact = (x * y) / scale;
			OP_DIV: begin
				if (y == 0) begin
					arith = 1'b0;
					r.st = ST_DIV0;
				end else
					exact = (x * scale) / y;
			end
			OP_INC:      exact = x + 1;
			OP_DEC:      exact = x - 1;
			OP_LT:       begin r.cmp = x < y;  arith = 1'b0; end
			OP_GT:       begin r.cmp = x > y;  arith = 1'b0; end
			OP_LE:       begin r.cmp = x <= y; arith = 1'b0; end
			OP_GE:       begin r.cmp = x >= y; arith = 1'b0; end
			OP_EQ:       begin r.cmp = x == y; arith = 1'b0; end
			OP_NE:       begin r.cmp = x != y; arith = 1'b0; end
			OP_MIN:      begin exact = (x < y) ? x : y; arith = 1'b0; end
			OP_MAX:      begin exact = (x > y) ? x : y; arith = 1'b0; end
			OP_TO_INT:   begin exact = x / scale; arith = 1'b0; end
			default:     exact = x * scale;
		endcase
		r.value = exact[WORD_W-1:0];
		// wrapped if the low word does not sign-extend back to the exact value
		if (arith && longint'(signed'(exact[WORD_W-1:0])) != exact)
			r.st = ST_OVF;
		return r;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk) begin
		alu_word_t e;
		int errs;
		errs = 0;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_words.push_back(alu_predict(req_type, operand_a, operand_b));
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word %h", result_value);
					errs++;
				end else begin
					e = expected_words.pop_front();
					if (result_value !== e.value) begin
						$error("result_value exp %h got %h", e.value, result_value);
						errs++;
					end
					if (compare_true !== e.cmp) begin
						$error("compare_true exp %b got %b", e.cmp, compare_true);
						errs++;
					end
					if (status !== e.st) begin
						$error("status exp %0d got %0d", e.st, status);
						errs++;
					end
				end
			end
		end
		if (errs != 0)
			fail_count <= fail_count + errs;
	end

	initial fail_count = 0;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the fixed-point ALU
// Directed corner requests, then random requests with random gaps on both
// sides; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
	import fpa_pkg::*;

	localparam int LATENCY   = 46;
	localparam int WD_LIMIT  = 2000;   // idle cycles tolerated before giving up
	localparam int N_RANDOM  = 1130;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [3:0]               req_type;
	logic signed [WORD_W-1:0] operand_a;
	logic signed [WORD_W-1:0] operand_b;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [WORD_W-1:0] result_value;
	logic                     compare_true;
	logic [1:0]               status;
	int                       fail_count;
	int                       pending;
	int                       idle_cycles;
	logic                     stim_done;

	fixed_point_alu uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .compare_true(compare_true), .status(status)
	);

	alu_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .compare_true(compare_true), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one request word: optional random gap, then hold valid until taken.
	// Valid stays up after the edge that takes the word; the next call or
	// the caller drops it.
	task automatic send_word(op_t op, logic [31:0] a, logic [31:0] b, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= op;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Random operand: mix of full-range words, small values and edge words.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'($signed($urandom_range(0, 8)) - 4);
			3, 4:    return 32'($signed($urandom_range(0, 8192)) - 4096);
			5:       return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Receiver: every word gets a fresh random stall, often none.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (stim_done && pending == 0) stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		op_t op;
		bit quiet;
		idle_cycles = 0;
		stim_done = 1'b0;
		in_valid  = 1'b0;
		req_type  = '0;
		operand_a = '0;
		operand_b = '0;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every operation, divide by zero, wrap cases
		send_word(OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 0);
		send_word(OP_SUB, 32'h8000_0000, 32'h0000_0001, 0);
		send_word(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_word(OP_MUL, 32'hffff_ff00, 32'h0000_0080, 0);
		send_word(OP_DIV, 32'h0000_0100, 32'h0000_0000, 0);
		send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
		send_word(OP_DIV, 32'hffff_fd00, 32'h0000_0200, 0);
		send_word(OP_INC, 32'h7fff_ffff, 32'hffff_ffff, 0);
		send_word(OP_DEC, 32'h8000_0000, 32'h1234_5678, 0);
		send_word(OP_LT,  32'h8000_0000, 32'h7fff_ffff, 0);
		send_word(OP_GT,  32'h8000_0000, 32'h7fff_ffff, 0);
		send_word(OP_LE,  32'h0000_0005, 32'h0000_0005, 0);
		send_word(OP_GE,  32'hffff_ffff, 32'h0000_0000, 0);
		send_word(OP_EQ,  32'hffff_ffff, 32'hffff_ffff, 0);
		send_word(OP_NE,  32'hffff_ffff, 32'hffff_ffff, 0);
		send_word(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_word(OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_word(OP_TO_INT, 32'hffff_ff01, 32'h0, 0);
		send_word(OP_TO_INT, 32'h8000_0000, 32'hffff_ffff, 0);
		send_word(OP_FROM_INT, 32'h0080_0000, 32'h0, 0);
		send_word(OP_FROM_INT, 32'hff80_0000, 32'h0, 0);
		in_valid <= 1'b0;

		// hold off until the pipeline has drained completely
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 200 == 0) quiet = ($urandom_range(0, 1) == 1);
			op = op_t'($urandom_range(0, 15));
			send_word(op, pick_operand(),
				($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand(), !quiet);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;

		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_div.sv
rtl/core/fixed_point_alu.sv
bench/alu_checker.sv
bench/tb_top.sv
